### design/imag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imag_pkg
// shared types and constants for the inverse-map address generator
// ----------------------------------------------------------------------------
package imag_pkg;

    typedef enum logic [2:0] {
        MODE_SHIFT  = 3'd0,
        MODE_ZOOM   = 3'd1,
        MODE_HFLIP  = 3'd2,
        MODE_VFLIP  = 3'd3,
        MODE_CW90   = 3'd4,
        MODE_CCW90  = 3'd5,
        MODE_ROT180 = 3'd6,
        MODE_ROTATE = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_IN_WIDTH    = 3'd1,
        REG_IN_HEIGHT   = 3'd2,
        REG_PIXEL_BYTES = 3'd3,
        REG_COEF_X      = 3'd4,
        REG_COEF_Y      = 3'd5,
        REG_OFFSET_X    = 3'd6,
        REG_OFFSET_Y    = 3'd7
    } reg_index_t;

    localparam int FRAC_BITS = 16;

    // product, sum and rounded-coordinate widths
    localparam int PROD_W  = 40;
    localparam int SUM_W   = 42;
    localparam int COORD_W = SUM_W - FRAC_BITS;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] FRAC_MASK  = (SUM_W'(1) <<< FRAC_BITS) - SUM_W'(1);

    localparam logic signed [COORD_W-1:0] SAT_MAX = COORD_W'(8191);
    localparam logic signed [COORD_W-1:0] SAT_MIN = -COORD_W'(8192);

    localparam logic [7:0] FILL_SHIFT = 8'd0;
    localparam logic [7:0] FILL_OTHER = 8'd255;

endpackage
`default_nettype wire

### design/image_inverse_map_address_gen_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_inverse_map_address_gen_unit
// nearest-neighbor inverse mapping: output pixel to source pixel and address
// ----------------------------------------------------------------------------
// One output pixel coordinate is taken in every clock cycle (busy stays low)
// and its result leaves the five register stages as a one-cycle strobe on done.
// The five register stages are: the four coefficient multipliers, the
// rotation sums, the half-LSB rounding and mode select, the range check with
// the row-stride and pixel-size multipliers, and the final address add.
// The receiver cannot stall the block, so results must be taken as they come.
// Configuration is written via the always-ready cfg channel; users must do so
// while no transaction is in flight (unchecked); stride is registered from it.
module image_inverse_map_address_gen_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [12:0]        out_row,
    input  wire logic [12:0]        out_col,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [29:0]        cfg_data,
    output logic                    done,
    output logic signed [13:0]      src_col,
    output logic signed [13:0]      src_row,
    output logic [25:0]             src_address,
    output logic                    in_range,
    output logic [7:0]              fill_byte
);

    localparam int PW = imag_pkg::PROD_W;
    localparam int SW = imag_pkg::SUM_W;
    localparam int CW = imag_pkg::COORD_W;

    // configuration registers
    imag_pkg::mode_t     mode_reg;
    logic [12:0]         width_reg;
    logic [12:0]         height_reg;
    logic [2:0]          pbytes_reg;
    logic signed [25:0]  coef_x_reg;
    logic signed [25:0]  coef_y_reg;
    logic signed [29:0]  offset_x_reg;
    logic signed [29:0]  offset_y_reg;
    logic [15:0]         stride_reg;
    logic [15:0]         stride_next;
    logic [15:0]         wp;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= imag_pkg::MODE_SHIFT;
            width_reg    <= 13'd1;
            height_reg   <= 13'd1;
            pbytes_reg   <= 3'd3;
            coef_x_reg   <= 26'sd65536;
            coef_y_reg   <= 26'sd65536;
            offset_x_reg <= 30'sd0;
            offset_y_reg <= 30'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (imag_pkg::reg_index_t'(cfg_index))
                imag_pkg::REG_MODE:        mode_reg     <= imag_pkg::mode_t'(cfg_data[2:0]);
                imag_pkg::REG_IN_WIDTH:    width_reg    <= cfg_data[12:0];
                imag_pkg::REG_IN_HEIGHT:   height_reg   <= cfg_data[12:0];
                imag_pkg::REG_PIXEL_BYTES: pbytes_reg   <= cfg_data[2:0];
                imag_pkg::REG_COEF_X:      coef_x_reg   <= cfg_data[25:0];
                imag_pkg::REG_COEF_Y:      coef_y_reg   <= cfg_data[25:0];
                imag_pkg::REG_OFFSET_X:    offset_x_reg <= cfg_data[29:0];
                imag_pkg::REG_OFFSET_Y:    offset_y_reg <= cfg_data[29:0];
                default: ;
            endcase
        end
    end

    // line stride: width times pixel bytes rounded up to a multiple of four
    assign wp          = 16'(width_reg) * 16'(pbytes_reg);
    assign stride_next = (wp + 16'd3) & ~16'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stride_reg <= 16'd4;
        else
            stride_reg <= stride_next;
    end

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: coefficient products and the simple mappings
    logic signed [13:0]  i_s;
    logic signed [13:0]  j_s;
    logic signed [15:0]  i16;
    logic signed [15:0]  j16;
    logic signed [15:0]  w16;
    logic signed [15:0]  h16;
    logic signed [15:0]  ox_fl;
    logic signed [15:0]  oy_fl;
    logic signed [PW-1:0] jcx_next, icy_next, jcy_next, icx_next;
    logic signed [PW-1:0] jcx_reg, icy_reg, jcy_reg, icx_reg;
    logic signed [15:0]  c1_next, r1_next;
    logic signed [15:0]  c1_reg, r1_reg;

    assign i_s   = {1'b0, out_row};
    assign j_s   = {1'b0, out_col};
    assign i16   = {3'b000, out_row};
    assign j16   = {3'b000, out_col};
    assign w16   = {3'b000, width_reg};
    assign h16   = {3'b000, height_reg};
    assign ox_fl = 16'(offset_x_reg >>> imag_pkg::FRAC_BITS);
    assign oy_fl = 16'(offset_y_reg >>> imag_pkg::FRAC_BITS);

    assign jcx_next = j_s * coef_x_reg;
    assign icy_next = i_s * coef_y_reg;
    assign jcy_next = j_s * coef_y_reg;
    assign icx_next = i_s * coef_x_reg;

    always_comb
    begin
        case (mode_reg)
            imag_pkg::MODE_SHIFT:
            begin
                c1_next = j16 + ox_fl;
                r1_next = i16 + oy_fl;
            end
            imag_pkg::MODE_HFLIP:
            begin
                c1_next = w16 - 16'sd1 - j16;
                r1_next = i16;
            end
            imag_pkg::MODE_VFLIP:
            begin
                c1_next = j16;
                r1_next = h16 - 16'sd1 - i16;
            end
            imag_pkg::MODE_CW90:
            begin
                c1_next = w16 - 16'sd1 - i16;
                r1_next = j16;
            end
            imag_pkg::MODE_CCW90:
            begin
                c1_next = i16;
                r1_next = h16 - 16'sd1 - j16;
            end
            imag_pkg::MODE_ROT180:
            begin
                c1_next = w16 - 16'sd1 - j16;
                r1_next = h16 - 16'sd1 - i16;
            end
            default:
            begin
                c1_next = j16;
                r1_next = i16;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        jcx_reg <= jcx_next;
        icy_reg <= icy_next;
        jcy_reg <= jcy_next;
        icx_reg <= icx_next;
        c1_reg  <= c1_next;
        r1_reg  <= r1_next;
    end

    // stage 2: rotation sums, or the plain zoom products
    logic signed [SW-1:0] vx_next, vy_next;
    logic signed [SW-1:0] vx_reg, vy_reg;
    logic signed [15:0]   c2_reg, r2_reg;

    always_comb
    begin
        if (mode_reg == imag_pkg::MODE_ZOOM)
        begin
            vx_next = SW'(jcx_reg);
            vy_next = SW'(icy_reg);
        end
        else
        begin
            vx_next = SW'(jcx_reg) - SW'(icy_reg) + SW'(offset_x_reg);
            vy_next = SW'(jcy_reg) + SW'(icx_reg) + SW'(offset_y_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        c2_reg <= c1_reg;
        r2_reg <= r1_reg;
    end

    // stage 3: add half and truncate toward zero, then pick per mode
    logic signed [SW-1:0] tx, ty;
    logic signed [SW-1:0] qx, qy;
    logic signed [CW-1:0] c3_next, r3_next;
    logic signed [CW-1:0] c3_reg, r3_reg;

    assign tx = vx_reg + imag_pkg::ROUND_HALF;
    assign ty = vy_reg + imag_pkg::ROUND_HALF;
    assign qx = (tx + (tx[SW-1] ? imag_pkg::FRAC_MASK : SW'(0))) >>> imag_pkg::FRAC_BITS;
    assign qy = (ty + (ty[SW-1] ? imag_pkg::FRAC_MASK : SW'(0))) >>> imag_pkg::FRAC_BITS;

    always_comb
    begin
        if (mode_reg == imag_pkg::MODE_ZOOM || mode_reg == imag_pkg::MODE_ROTATE)
        begin
            c3_next = CW'(qx);
            r3_next = CW'(qy);
        end
        else
        begin
            c3_next = CW'(c2_reg);
            r3_next = CW'(r2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        c3_reg <= c3_next;
        r3_reg <= r3_next;
    end

    // stage 4: range check, saturation, address partial products
    logic                 ok4_next, ok4_reg;
    logic signed [13:0]   col4_next, row4_next;
    logic signed [13:0]   col4_reg, row4_reg;
    logic [28:0]          prow_next, prow_reg;
    logic [15:0]          pcol_next, pcol_reg;

    assign ok4_next = !c3_reg[CW-1] && (c3_reg[CW-2:0] < (CW-1)'(width_reg))
                   && !r3_reg[CW-1] && (r3_reg[CW-2:0] < (CW-1)'(height_reg));

    always_comb
    begin
        if (c3_reg > imag_pkg::SAT_MAX)
            col4_next = 14'(imag_pkg::SAT_MAX);
        else if (c3_reg < imag_pkg::SAT_MIN)
            col4_next = 14'(imag_pkg::SAT_MIN);
        else
            col4_next = 14'(c3_reg);

        if (r3_reg > imag_pkg::SAT_MAX)
            row4_next = 14'(imag_pkg::SAT_MAX);
        else if (r3_reg < imag_pkg::SAT_MIN)
            row4_next = 14'(imag_pkg::SAT_MIN);
        else
            row4_next = 14'(r3_reg);
    end

    assign prow_next = 29'(r3_reg[12:0]) * 29'(stride_reg);
    assign pcol_next = 16'(c3_reg[12:0]) * 16'(pbytes_reg);

    always_ff @(posedge clk)
    begin
        ok4_reg  <= ok4_next;
        col4_reg <= col4_next;
        row4_reg <= row4_next;
        prow_reg <= prow_next;
        pcol_reg <= pcol_next;
    end

    // stage 5: address sum and result registers
    logic [25:0]        addr_next;
    logic [25:0]        addr_reg;
    logic signed [13:0] col5_reg, row5_reg;
    logic               ok5_reg;
    logic [7:0]         fill_reg;

    assign addr_next = ok4_reg ? (26'(prow_reg) + 26'(pcol_reg)) : 26'd0;

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        col5_reg <= col4_reg;
        row5_reg <= row4_reg;
        ok5_reg  <= ok4_reg;
        fill_reg <= (mode_reg == imag_pkg::MODE_SHIFT) ? imag_pkg::FILL_SHIFT
                                                       : imag_pkg::FILL_OTHER;
    end

    assign done        = v5_reg;
    assign src_col     = col5_reg;
    assign src_row     = row5_reg;
    assign src_address = addr_reg;
    assign in_range    = ok5_reg;
    assign fill_byte   = fill_reg;

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inverse-map address generator. Output pixel
// coordinates are sent through the start/busy port with random gaps. A
// scoreboard class predicts the source column, source row, byte address,
// in-range flag and fill byte of each pixel and checks every result strobe
// against the oldest prediction. Registers are rewritten between phases
// once the pipeline is empty. The run covers all eight modes, the field
// extremes, zero sizes, address overflow and saturated coordinates.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     PIXEL_TARGET = 1130;
    localparam int     QUIET_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     MAX_GAP      = 17;
    localparam int     MAX_REPORTS  = 10;
    localparam longint ONE_Q        = 64'sd1 <<< imag_pkg::FRAC_BITS;

    typedef struct {
        logic signed [13:0] col;
        logic signed [13:0] row;
        logic [25:0]        addr;
        logic               hit;
        logic [7:0]         fill;
    } source_pixel_t;

    class source_map_checker;
        imag_pkg::mode_t mode;
        logic [12:0]     width;
        logic [12:0]     height;
        logic [2:0]      pix_bytes;
        longint          coef_x;
        longint          coef_y;
        longint          off_x;
        longint          off_y;
        source_pixel_t   expected_src[$];
        int              errors;
        int              checked;
        int              hit_count;

        function new();
            mode      = imag_pkg::MODE_SHIFT;
            width     = 13'd1;
            height    = 13'd1;
            pix_bytes = 3'd3;
            coef_x    = ONE_Q;
            coef_y    = ONE_Q;
            off_x     = 0;
            off_y     = 0;
            errors    = 0;
            checked   = 0;
            hit_count = 0;
        endfunction

        function void set_reg(imag_pkg::reg_index_t idx, logic [29:0] data);
            case (idx)
                imag_pkg::REG_MODE:        mode = imag_pkg::mode_t'(data[2:0]);
                imag_pkg::REG_IN_WIDTH:    width = data[12:0];
                imag_pkg::REG_IN_HEIGHT:   height = data[12:0];
                imag_pkg::REG_PIXEL_BYTES: pix_bytes = data[2:0];
                imag_pkg::REG_COEF_X:      coef_x = $signed(data[25:0]);
                imag_pkg::REG_COEF_Y:      coef_y = $signed(data[25:0]);
                imag_pkg::REG_OFFSET_X:    off_x = $signed(data);
                imag_pkg::REG_OFFSET_Y:    off_y = $signed(data);
                default:                   ;
            endcase
        endfunction

        // add half an lsb, then truncate toward zero
        function longint round_fixed(longint v);
            longint t;
            t = v + (ONE_Q >>> 1);
            if (t < 0)
                return -((-t) >>> imag_pkg::FRAC_BITS);
            return t >>> imag_pkg::FRAC_BITS;
        endfunction

        function longint clamp14(longint v);
            if (v < -8192)
                return -8192;
            if (v > 8191)
                return 8191;
            return v;
        endfunction

        function source_pixel_t map_source(logic [12:0] orow, logic [12:0] ocol);
            longint        i;
            longint        j;
            longint        w;
            longint        h;
            longint        pb;
            longint        c;
            longint        r;
            longint        stride;
            longint        addr;
            source_pixel_t res;
            i  = orow;
            j  = ocol;
            w  = width;
            h  = height;
            pb = pix_bytes;
            case (mode)
                imag_pkg::MODE_SHIFT:
                begin
                    c = j + (off_x >>> imag_pkg::FRAC_BITS);
                    r = i + (off_y >>> imag_pkg::FRAC_BITS);
                end
                imag_pkg::MODE_ZOOM:
                begin
                    c = round_fixed(j * coef_x);
                    r = round_fixed(i * coef_y);
                end
                imag_pkg::MODE_HFLIP:
                begin
                    c = w - 1 - j;
                    r = i;
                end
                imag_pkg::MODE_VFLIP:
                begin
                    c = j;
                    r = h - 1 - i;
                end
                imag_pkg::MODE_CW90:
                begin
                    c = w - 1 - i;
                    r = j;
                end
                imag_pkg::MODE_CCW90:
                begin
                    c = i;
                    r = h - 1 - j;
                end
                imag_pkg::MODE_ROT180:
                begin
                    c = w - 1 - j;
                    r = h - 1 - i;
                end
                default:
                begin
                    c = round_fixed(j * coef_x - i * coef_y + off_x);
                    r = round_fixed(j * coef_y + i * coef_x + off_y);
                end
            endcase
            res.hit = (c >= 0) && (c < w) && (r >= 0) && (r < h);
            addr = 0;
            if (res.hit)
            begin
                stride = (w * pb + 3) / 4 * 4;
                addr   = r * stride + c * pb;
            end
            res.col  = 14'(clamp14(c));
            res.row  = 14'(clamp14(r));
            res.addr = 26'(addr);
            res.fill = (mode == imag_pkg::MODE_SHIFT) ? imag_pkg::FILL_SHIFT
                                                      : imag_pkg::FILL_OTHER;
            return res;
        endfunction

        function void note_pixel(logic [12:0] orow, logic [12:0] ocol);
            expected_src.push_back(map_source(orow, ocol));
        endfunction

        function void check_source(logic signed [13:0] col, logic signed [13:0] row,
                                   logic [25:0] addr, logic hit, logic [7:0] fill);
            source_pixel_t exp_px;
            if (expected_src.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: col=%0d row=%0d addr=%0h in=%0b fill=%0d",
                             col, row, addr, hit, fill);
                return;
            end
            exp_px = expected_src.pop_front();
            checked++;
            if (hit === 1'b1)
                hit_count++;
            if (col !== exp_px.col || row !== exp_px.row || addr !== exp_px.addr ||
                hit !== exp_px.hit || fill !== exp_px.fill)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"mismatch: exp col=%0d row=%0d addr=%0h in=%0b fill=%0d, ",
                              "got col=%0d row=%0d addr=%0h in=%0b fill=%0d"},
                             exp_px.col, exp_px.row, exp_px.addr, exp_px.hit,
                             exp_px.fill, col, row, addr, hit, fill);
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic [12:0]        out_row   = '0;
    logic [12:0]        out_col   = '0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [29:0]        cfg_data  = '0;
    logic               busy;
    logic               cfg_ready;
    logic               done;
    logic signed [13:0] src_col;
    logic signed [13:0] src_row;
    logic [25:0]        src_address;
    logic               in_range;
    logic [7:0]         fill_byte;

    source_map_checker sb = new();
    int                pixels_sent = 0;
    int                settings_applied = 0;

    image_inverse_map_address_gen_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .out_row     (out_row),
        .out_col     (out_col),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .src_col     (src_col),
        .src_row     (src_row),
        .src_address (src_address),
        .in_range    (in_range),
        .fill_byte   (fill_byte)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check_source(src_col, src_row, src_address, in_range, fill_byte);

    function automatic longint rand_between(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    // one transaction per call, start stays high for a following zero gap
    task automatic send_pixel(input logic [12:0] row, input logic [12:0] col, input int gap);
        if (gap > 0)
        begin
            @(negedge clk) start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        out_row <= row;
        out_col <= col;
        do
            @(posedge clk);
        while (busy);
        sb.note_pixel(row, col);
        pixels_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk) start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_src.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input imag_pkg::reg_index_t idx, input logic [29:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_setting(input imag_pkg::mode_t m, input longint w, input longint h,
                                 input longint pb, input longint cx, input longint cy,
                                 input longint ox, input longint oy);
        logic [29:0]          vals[8];
        int                   first;
        int                   k;
        imag_pkg::reg_index_t idx;
        stop_sending();
        wait_drained();
        vals[imag_pkg::REG_MODE]        = 30'(m);
        vals[imag_pkg::REG_IN_WIDTH]    = 30'(w);
        vals[imag_pkg::REG_IN_HEIGHT]   = 30'(h);
        vals[imag_pkg::REG_PIXEL_BYTES] = 30'(pb);
        vals[imag_pkg::REG_COEF_X]      = 30'(cx);
        vals[imag_pkg::REG_COEF_Y]      = 30'(cy);
        vals[imag_pkg::REG_OFFSET_X]    = 30'(ox);
        vals[imag_pkg::REG_OFFSET_Y]    = 30'(oy);
        first = $urandom_range(0, 7);
        for (k = 0; k < 8; k++)
        begin
            idx = imag_pkg::reg_index_t'((first + k) % 8);
            write_reg(idx, vals[idx]);
        end
        @(negedge clk) cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic random_phase(input int phase);
        imag_pkg::mode_t m;
        longint          w;
        longint          h;
        longint          pb;
        longint          cx;
        longint          cy;
        longint          ox;
        longint          oy;
        longint          row_span;
        longint          col_span;
        int              roll;
        int              count;
        int              hold_at;
        int              k;
        bit              burst;
        bit              raw_regs;
        real             ang;
        logic [12:0]     row;
        logic [12:0]     col;
        m        = imag_pkg::mode_t'(phase % 8);
        raw_regs = 1'b0;
        roll     = $urandom_range(0, 99);
        w        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
        h        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
        pb       = $urandom_range(1, 4);
        if (roll < 8)
        begin
            // zero width, height or pixel size
            case ($urandom_range(0, 2))
                0:       w = 0;
                1:       h = 0;
                default: pb = 0;
            endcase
        end
        else if (roll < 16)
        begin
            w  = 4096;
            h  = 4096;
            pb = 4;
        end
        else if (roll < 24)
        begin
            w  = 1;
            h  = 1;
            pb = 1;
        end
        else if (roll < 32)
        begin
            // registers beyond their nominal ranges, address overflow
            w        = $urandom_range(4097, 8191);
            h        = $urandom_range(4097, 8191);
            pb       = $urandom_range(0, 7);
            raw_regs = 1'b1;
        end
        cx = rand_between(-(64'sd1 <<< 25), (64'sd1 <<< 25) - 1);
        cy = rand_between(-(64'sd1 <<< 25), (64'sd1 <<< 25) - 1);
        ox = rand_between(-(64'sd1 <<< 29), (64'sd1 <<< 29) - 1);
        oy = rand_between(-(64'sd1 <<< 29), (64'sd1 <<< 29) - 1);
        if (!raw_regs)
        begin
            if (m == imag_pkg::MODE_SHIFT)
            begin
                ox = rand_between(-(w + 8) * ONE_Q, (w + 8) * ONE_Q);
                oy = rand_between(-(h + 8) * ONE_Q, (h + 8) * ONE_Q);
            end
            else if (m == imag_pkg::MODE_ZOOM)
            begin
                cx = rand_between(64'sd1 <<< 14, 64'sd1 <<< 18);
                cy = rand_between(64'sd1 <<< 14, 64'sd1 <<< 18);
                if ($urandom_range(0, 7) == 0)
                    cx = -cx;
                if ($urandom_range(0, 7) == 0)
                    cy = -cy;
            end
            else if (m == imag_pkg::MODE_ROTATE)
            begin
                ang = $urandom_range(0, 359) * 3.1415926 / 180.0;
                cx  = $rtoi($cos(ang) * 65536.0);
                cy  = $rtoi($sin(ang) * 65536.0);
                ox  = (w / 2) * ONE_Q - ((w / 2) * cx - (h / 2) * cy);
                oy  = (h / 2) * ONE_Q - ((w / 2) * cy + (h / 2) * cx);
            end
            if ($urandom_range(0, 7) == 0)
                cx = $urandom_range(0, 1) ? (64'sd1 <<< 24) : -(64'sd1 <<< 24);
            if ($urandom_range(0, 7) == 0)
                cy = $urandom_range(0, 1) ? (64'sd1 <<< 24) : -(64'sd1 <<< 24);
            if ($urandom_range(0, 7) == 0)
                ox = $urandom_range(0, 1) ? (64'sd1 <<< 28) : -(64'sd1 <<< 28);
            if ($urandom_range(0, 7) == 0)
                oy = $urandom_range(0, 1) ? (64'sd1 <<< 28) : -(64'sd1 <<< 28);
        end
        apply_setting(m, w, h, pb, cx, cy, ox, oy);

        // bias coordinates toward the part of the output that maps inside
        col_span = w;
        row_span = h;
        if (m == imag_pkg::MODE_CW90 || m == imag_pkg::MODE_CCW90)
        begin
            col_span = h;
            row_span = w;
        end
        else if (m == imag_pkg::MODE_ZOOM)
        begin
            if (sb.coef_x > 0)
                col_span = w * ONE_Q / sb.coef_x;
            if (sb.coef_y > 0)
                row_span = h * ONE_Q / sb.coef_y;
        end
        else if (m == imag_pkg::MODE_ROTATE)
        begin
            col_span = (w > h) ? w : h;
            row_span = col_span;
        end
        else if (m == imag_pkg::MODE_SHIFT)
        begin
            if (sb.off_x < 0)
                col_span = w - (sb.off_x >>> imag_pkg::FRAC_BITS);
            if (sb.off_y < 0)
                row_span = h - (sb.off_y >>> imag_pkg::FRAC_BITS);
        end
        col_span = (col_span + 4 > 8191) ? 8191 : col_span + 4;
        row_span = (row_span + 4 > 8191) ? 8191 : row_span + 4;

        count   = $urandom_range(16, 40);
        hold_at = ($urandom_range(0, 3) == 0 || phase == 0)
                ? $urandom_range(1, count - 1) : -1;
        burst   = ($urandom_range(0, 3) == 0);
        for (k = 0; k < count; k++)
        begin
            if (k == hold_at)
            begin
                stop_sending();
                wait_drained();
            end
            if ($urandom_range(0, 4) == 0)
            begin
                row = 13'($urandom);
                col = 13'($urandom);
            end
            else
            begin
                row = 13'($urandom_range(0, int'(row_span)));
                col = 13'($urandom_range(0, int'(col_span)));
            end
            send_pixel(row, col, burst ? 0 : $urandom_range(0, MAX_GAP));
        end
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int              k;
        int              phase;
        imag_pkg::mode_t m;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // settings straight out of reset
        send_pixel(13'd0, 13'd0, $urandom_range(0, MAX_GAP));
        send_pixel(13'd8191, 13'd8191, $urandom_range(0, MAX_GAP));

        // every mode at the coordinate extremes and one interior point
        for (k = 0; k < 8; k++)
        begin
            m = imag_pkg::mode_t'(k);
            apply_setting(m, 640, 480, 3, 56756, 32768,
                          (m == imag_pkg::MODE_SHIFT) ? -294912 : 10673920,
                          (m == imag_pkg::MODE_SHIFT) ? 201268 : -8378560);
            send_pixel(13'd0, 13'd0, $urandom_range(0, MAX_GAP));
            send_pixel(13'd8191, 13'd8191, $urandom_range(0, MAX_GAP));
            send_pixel(13'd240, 13'd320, $urandom_range(0, MAX_GAP));
        end

        // zero pixel size, zero width, address overflow
        apply_setting(imag_pkg::MODE_VFLIP, 640, 480, 0, ONE_Q, ONE_Q, 0, 0);
        send_pixel(13'd10, 13'd20, $urandom_range(0, MAX_GAP));
        apply_setting(imag_pkg::MODE_VFLIP, 0, 480, 3, ONE_Q, ONE_Q, 0, 0);
        send_pixel(13'd10, 13'd20, $urandom_range(0, MAX_GAP));
        apply_setting(imag_pkg::MODE_ROT180, 8191, 8191, 7, ONE_Q, ONE_Q, 0, 0);
        send_pixel(13'd0, 13'd0, $urandom_range(0, MAX_GAP));

        phase = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            random_phase(phase);
            phase++;
        end

        stop_sending();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d pixels over %0d register settings in all eight modes",
                 sb.checked, settings_applied);
        $display("%0d pixels mapped inside the source image, %0d outside",
                 sb.hit_count, sb.checked - sb.hit_count);
        if (sb.errors == 0 && sb.expected_src.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
